// File: rtl/core/mws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mws_pkg
// Shared constants and types for the mirrored window sort block.
// ----------------------------------------------------------------------------
package mws_pkg;

   localparam int VALUE_WIDTH         = 32;
   localparam int DEFAULT_STORE_DEPTH = 64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SORT_RD,
      ST_SORT_CMP,
      ST_SORT_WRB,
      ST_EMIT
   } state_type;

endpackage

// File: rtl/core/mws_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mws_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module mws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // read data holds between reads
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

// File: rtl/core/mws_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mws_sched
// Walks the compare-exchange schedule: two stages of shrinking windows,
// mirrored pairs inside each window from both ends inward.
// ----------------------------------------------------------------------------
module mws_sched
   import mws_pkg::*;
#(
   parameter int STORE_DEPTH = DEFAULT_STORE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic [$clog2(STORE_DEPTH+1)-1:0] count,
   input  logic                           advance,
   output logic                           active,
   output logic [$clog2(STORE_DEPTH)-1:0] a_addr,
   output logic [$clog2(STORE_DEPTH)-1:0] b_addr
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);

   logic          active_ff, active_in;
   logic          stage_ff, stage_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] a_ff, a_in;
   logic [CW-1:0] b_ff, b_in;

   always_comb begin
      active_in = active_ff;
      stage_in  = stage_ff;
      n_in      = n_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      if (load) begin
         n_in      = count;
         stage_in  = 1'b0;
         lo_in     = '0;
         hi_in     = count - CW'(1);
         a_in      = '0;
         b_in      = count - CW'(1);
         active_in = (count > CW'(1));
      end else if (advance && active_ff) begin
         if (a_ff + CW'(2) < b_ff) begin
            // next pair inside the same window
            a_in = a_ff + CW'(1);
            b_in = b_ff - CW'(1);
         end else if (!stage_ff && hi_ff > CW'(1)) begin
            // stage one: right end shrinks
            hi_in = hi_ff - CW'(1);
            a_in  = lo_ff;
            b_in  = hi_ff - CW'(1);
         end else if (stage_ff && lo_ff + CW'(1) < hi_ff) begin
            // stage two: left end grows
            lo_in = lo_ff + CW'(1);
            a_in  = lo_ff + CW'(1);
            b_in  = hi_ff;
         end else if (!stage_ff) begin
            stage_in = 1'b1;
            lo_in    = '0;
            hi_in    = n_ff - CW'(1);
            a_in     = '0;
            b_in     = n_ff - CW'(1);
         end else begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         stage_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         stage_ff  <= stage_in;
      end
      n_ff  <= n_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      a_ff  <= a_in;
      b_ff  <= b_in;
   end

   assign active = active_ff;
   assign a_addr = a_ff[AW-1:0];
   assign b_addr = b_ff[AW-1:0];

endmodule

// File: rtl/core/mirrored_window_sort.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mirrored_window_sort
// Collects signed elements into a RAM, sorts them in place with a two-stage
// mirrored-window compare-exchange schedule and streams them out ascending.
// ----------------------------------------------------------------------------
// an ordinary element is written to the RAM while idle, busy stays low
// last element: each compare-exchange pair passes ST_SORT_RD (read) and ST_SORT_CMP
//   (compare), and ST_SORT_WRB too when it swaps since the RAM has one write port,
//   over about n*n/2 pairs; the schedule then closes and n beats follow back to back
// results are strobed for one cycle each; the receiver cannot stall
// synchronous reset clears count, overflow flag and control; RAM is not cleared
module mirrored_window_sort
   import mws_pkg::*;
#(
   parameter int STORE_DEPTH = DEFAULT_STORE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [VALUE_WIDTH-1:0] req_element_value,
   input  logic                   req_last_item,
   output logic                   rsp_strobe,
   output logic [VALUE_WIDTH-1:0] rsp_sorted_value,
   output logic                   rsp_last_result,
   output logic                   rsp_dropped_flag
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          overflow_ff, overflow_in;
   logic [AW-1:0] emit_idx_ff, emit_idx_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_dropped_ff, rsp_dropped_in;

   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [VALUE_WIDTH-1:0] ram_wr_data;
   logic                   ram_rd_en;
   logic [AW-1:0]          ram_rd_addr_a;
   logic [VALUE_WIDTH-1:0] ram_rd_data_a;
   logic [VALUE_WIDTH-1:0] ram_rd_data_b;

   logic          sched_load;
   logic          sched_advance;
   logic          sched_active;
   logic [AW-1:0] sched_a_addr;
   logic [AW-1:0] sched_b_addr;

   mws_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (STORE_DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_en     (ram_rd_en),
      .rd_addr_a (ram_rd_addr_a),
      .rd_addr_b (sched_b_addr),
      .rd_data_a (ram_rd_data_a),
      .rd_data_b (ram_rd_data_b)
   );

   mws_sched #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_sched (
      .clock   (clock),
      .reset   (reset),
      .load    (sched_load),
      .count   (count_in),
      .advance (sched_advance),
      .active  (sched_active),
      .a_addr  (sched_a_addr),
      .b_addr  (sched_b_addr)
   );

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      overflow_in    = overflow_ff;
      emit_idx_in    = emit_idx_ff;
      rsp_strobe_in  = 1'b0;
      rsp_last_in    = rsp_last_ff;
      rsp_dropped_in = rsp_dropped_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = sched_a_addr;
      ram_wr_data    = ram_rd_data_b;
      ram_rd_en      = 1'b0;
      ram_rd_addr_a  = sched_a_addr;
      sched_load     = 1'b0;
      sched_advance  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (count_ff < CW'(STORE_DEPTH)) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = count_ff[AW-1:0];
                  ram_wr_data = req_element_value;
                  count_in    = count_ff + CW'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_last_item) begin
                  sched_load = 1'b1;
                  state_in   = ST_SORT_RD;
               end
            end
         end
         ST_SORT_RD: begin
            if (sched_active) begin
               ram_rd_en = 1'b1;
               state_in  = ST_SORT_CMP;
            end else begin
               emit_idx_in = '0;
               state_in    = ST_EMIT;
            end
         end
         ST_SORT_CMP: begin
            if ($signed(ram_rd_data_a) > $signed(ram_rd_data_b)) begin
               // left gets the right value now, right gets the held left next
               ram_wr_en   = 1'b1;
               ram_wr_addr = sched_a_addr;
               ram_wr_data = ram_rd_data_b;
               state_in    = ST_SORT_WRB;
            end else begin
               sched_advance = 1'b1;
               state_in      = ST_SORT_RD;
            end
         end
         ST_SORT_WRB: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = sched_b_addr;
            ram_wr_data   = ram_rd_data_a;
            sched_advance = 1'b1;
            state_in      = ST_SORT_RD;
         end
         ST_EMIT: begin
            ram_rd_en      = 1'b1;
            ram_rd_addr_a  = emit_idx_ff;
            rsp_strobe_in  = 1'b1;
            rsp_dropped_in = overflow_ff;
            rsp_last_in    = (CW'(emit_idx_ff) + CW'(1) == count_ff);
            emit_idx_in    = emit_idx_ff + AW'(1);
            if (rsp_last_in) begin
               count_in    = '0;
               overflow_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         overflow_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         overflow_ff   <= overflow_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      emit_idx_ff    <= emit_idx_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_sorted_value = ram_rd_data_a;
   assign rsp_last_result  = rsp_last_ff;
   assign rsp_dropped_flag = rsp_dropped_ff;

endmodule

// File: bench/mirrored_window_sort_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mirrored_window_sort_test
// Self-checking bench for the mirrored window sort block. Lists of signed
// elements go in through the start/busy port. A scoreboard runs the same
// two-stage mirrored compare-exchange schedule on each list and checks every
// strobed result beat, including the last and dropped marks.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic signed [mws_pkg::VALUE_WIDTH-1:0] value;
   logic                                   last;
   logic                                   dropped;
} sorted_beat_type;

class window_sort_checker;
   logic signed [mws_pkg::VALUE_WIDTH-1:0] held [mws_pkg::DEFAULT_STORE_DEPTH];
   int              held_count;
   bit              overflow_seen;
   sorted_beat_type pending_beats[$];
   int              error_count;
   int              beats_checked;
   int              lists_sorted;
   int              overflow_lists;

   // two stages of n windows; stage one pulls hi in, stage two pushes lo out
   function void sort_held(int n);
      int lo;
      int hi;
      int remaining;
      logic signed [mws_pkg::VALUE_WIDTH-1:0] swap_value;
      for (int stage = 0; stage < 2; stage++) begin
         lo = 0;
         hi = n - 1;
         remaining = n;
         for (int w = 0; w < n; w++) begin
            for (int k = 0; k < remaining / 2; k++) begin
               if (held[lo + k] > held[hi - k]) begin
                  swap_value = held[lo + k];
                  held[lo + k] = held[hi - k];
                  held[hi - k] = swap_value;
               end
            end
            if (stage == 0) hi--;
            else lo++;
            remaining--;
         end
      end
   endfunction

   function void note_element(logic signed [mws_pkg::VALUE_WIDTH-1:0] value, logic last);
      sorted_beat_type beat;
      if (held_count < mws_pkg::DEFAULT_STORE_DEPTH) begin
         held[held_count] = value;
         held_count++;
      end else begin
         overflow_seen = 1'b1;
      end
      if (last) begin
         sort_held(held_count);
         for (int i = 0; i < held_count; i++) begin
            beat.value   = held[i];
            beat.last    = (i == held_count - 1);
            beat.dropped = overflow_seen;
            pending_beats.push_back(beat);
         end
         lists_sorted++;
         if (overflow_seen) overflow_lists++;
         held_count = 0;
         overflow_seen = 1'b0;
      end
   endfunction

   function void check_beat(logic [mws_pkg::VALUE_WIDTH-1:0] value, logic last, logic dropped);
      sorted_beat_type want;
      if (pending_beats.size() == 0) begin
         $error("unexpected result beat: sorted_value %0d", $signed(value));
         error_count++;
         return;
      end
      want = pending_beats.pop_front();
      beats_checked++;
      if (value !== want.value) begin
         $error("sorted_value mismatch: expected %0d, actual %0d", want.value, $signed(value));
         error_count++;
      end
      if (last !== want.last) begin
         $error("last_result mismatch: expected %0b, actual %0b", want.last, last);
         error_count++;
      end
      if (dropped !== want.dropped) begin
         $error("dropped_flag mismatch: expected %0b, actual %0b", want.dropped, dropped);
         error_count++;
      end
   endfunction
endclass

module mirrored_window_sort_test;
   import mws_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int BIG_LIST     = DEFAULT_STORE_DEPTH;
   localparam logic signed [VALUE_WIDTH-1:0] MOST_NEGATIVE = 32'sh8000_0000;
   localparam logic signed [VALUE_WIDTH-1:0] MOST_POSITIVE = 32'sh7fff_ffff;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [VALUE_WIDTH-1:0] req_element_value;
   logic                   req_last_item;
   logic                   rsp_strobe;
   logic [VALUE_WIDTH-1:0] rsp_sorted_value;
   logic                   rsp_last_result;
   logic                   rsp_dropped_flag;

   window_sort_checker sort_chk = new();
   int cycle_count;
   int elements_sent;

   mirrored_window_sort #(
      .STORE_DEPTH(DEFAULT_STORE_DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_element_value(req_element_value),
      .req_last_item    (req_last_item),
      .rsp_strobe       (rsp_strobe),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_result  (rsp_last_result),
      .rsp_dropped_flag (rsp_dropped_flag)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sort_chk.check_beat(rsp_sorted_value, rsp_last_result, rsp_dropped_flag);
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // holds the beat until the block takes it; start stays high on return
   task automatic send_element(input logic signed [VALUE_WIDTH-1:0] value, input logic last);
      req_element_value <= value;
      req_last_item     <= last;
      start             <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sort_chk.note_element(value, last);
      elements_sent++;
   endtask

   task automatic idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clock);
   endtask

   task automatic send_list(input logic signed [VALUE_WIDTH-1:0] values[$], input bit allow_idle);
      foreach (values[i]) begin
         if (allow_idle && $urandom_range(0, 3) == 0) idle_burst();
         send_element(values[i], i == values.size() - 1);
      end
   endtask

   function automatic logic signed [VALUE_WIDTH-1:0] random_value();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: return MOST_NEGATIVE;
               1: return MOST_POSITIVE;
               2: return '0;
               default: return -1;
            endcase
         end
         // narrow range so duplicates show up
         1, 2: return $urandom_range(0, 8) - 4;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_list(input int length, input bit allow_idle);
      logic signed [VALUE_WIDTH-1:0] values[$];
      for (int i = 0; i < length; i++) values.push_back(random_value());
      send_list(values, allow_idle);
   endtask

   initial begin
      reset             <= 1'b1;
      start             <= 1'b0;
      req_element_value <= '0;
      req_last_item     <= 1'b0;
      elements_sent     = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // one-element list, extremes in descending order, duplicates, presorted input
      send_list('{32'sd42}, 1'b0);
      send_list('{MOST_POSITIVE, MOST_NEGATIVE}, 1'b0);
      send_list('{MOST_POSITIVE, 32'sd1, 32'sd0, -32'sd1, MOST_NEGATIVE}, 1'b0);
      send_list('{32'sh5555_5555, 32'shaaaa_aaaa, 32'sd7, -32'sd3, 32'sd7, -32'sd3,
                  32'sd7, 32'sd0}, 1'b1);
      send_list('{-32'sd2, -32'sd1, 32'sd0, 32'sd1, 32'sd2, 32'sd3}, 1'b1);

      for (int l = 0; l < 8; l++) send_random_list($urandom_range(1, 8), 1'b1);
      // fill the store and run past it so the tail, the last element with it, is dropped
      send_random_list(BIG_LIST + 2, 1'b1);
      for (int l = 0; l < 5; l++) send_random_list($urandom_range(2, 8), 1'b1);
      // back-to-back tail with no gaps
      for (int l = 0; l < 5; l++) send_random_list($urandom_range(1, 8), 1'b0);

      start <= 1'b0;
      while (sort_chk.pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sorted %0d lists from %0d elements, %0d of them with dropped elements",
               sort_chk.lists_sorted, elements_sent, sort_chk.overflow_lists);
      $display("checked %0d result beats, %0d errors", sort_chk.beats_checked,
               sort_chk.error_count);
      if (sort_chk.error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/mws_pkg.sv
rtl/core/mws_ram.sv
rtl/core/mws_sched.sv
rtl/core/mirrored_window_sort.sv
bench/mirrored_window_sort_test.sv
